@@ rtl/rational_arith_reduce_unit_macros.svh @@
// Assertion macros shared by the rational arithmetic unit.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef RATIONAL_ARITH_REDUCE_UNIT_MACROS_SVH
`define RATIONAL_ARITH_REDUCE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RAR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RAR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rar_pkg.sv @@
// Package for the rational arithmetic unit: widths, codes and the queue entry.
// Used by rar_front, rar_queue, rar_back and rational_arith_reduce_unit.
package rar_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int NUM_W         = OPERAND_WIDTH;
  localparam int DEN_W         = OPERAND_WIDTH - 1;
  localparam int RES_NUM_W     = 32;
  localparam int RES_DEN_W     = 31;
  localparam int MAG_W         = 31;
  localparam int SHIFT_W       = $clog2(MAG_W);
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int IN_TDATA_W    = ((2 * NUM_W + 2 * DEN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W   = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_GCD,
    B_DIV,
    B_OUT
  } back_state_t;

  // Unreduced fraction handed from the front to the back.
  typedef struct packed {
    status_t                       status;
    logic signed [RES_NUM_W-1:0]   n;
    logic [RES_DEN_W-1:0]          d;
  } frac_t;

endpackage

@@ rtl/rational_arith_reduce_unit.sv @@
// Path: front register, queue, back-end load, binary gcd (one halving or subtract step
// per cycle), division (one quotient bit per cycle), output state, result register;
// error and zero results skip gcd, division and the output state. The back end takes
// no new fraction until the last is delivered, while the front and a two-entry queue
// keep accepting; error and zero items go out one per cycle while out_tready is high.
// Reset: rst_n synchronous, active low, clears control state; no result is held.
module rational_arith_reduce_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [15:0] num_a, [30:16] den_a, [46:31] num_b, [61:47] den_b, [63:62] zero
  input  logic [rar_pkg::IN_TDATA_W-1:0]        in_tdata,
  // [1:0] opcode
  input  logic [1:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [31:0] res_num, [62:32] res_den, [63] zero
  output logic [rar_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // [1:0] status
  output logic [1:0]                            out_tuser
);

  localparam int NW = rar_pkg::NUM_W;
  localparam int DW = rar_pkg::DEN_W;

  logic                                   q_full;
  logic                                   q_empty;
  logic                                   push;
  logic                                   pop;
  rar_pkg::frac_t                         push_data;
  rar_pkg::frac_t                         q_head;
  logic signed [rar_pkg::RES_NUM_W-1:0]   res_num;
  logic [rar_pkg::RES_DEN_W-1:0]          res_den;
  rar_pkg::status_t                       status;

  rar_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .opcode    (rar_pkg::opcode_t'(in_tuser)),
    .num_a     ($signed(in_tdata[NW-1:0])),
    .den_a     (in_tdata[NW+DW-1:NW]),
    .num_b     ($signed(in_tdata[2*NW+DW-1:NW+DW])),
    .den_b     (in_tdata[2*NW+2*DW-1:2*NW+DW]),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rar_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  rar_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_num   (res_num),
    .res_den   (res_den),
    .status    (status)
  );

  // Pack the result.
  assign out_tdata = rar_pkg::OUT_TDATA_W'({res_den, res_num});
  assign out_tuser = status;

endmodule

@@ rtl/rar_front.sv @@
// Front end: accepts a request, flags bad operands and cross-multiplies.
// Depends on rar_pkg; pushes one unreduced fraction per request into rar_queue.
module rar_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  rar_pkg::opcode_t                     opcode,
  input  logic signed [rar_pkg::NUM_W-1:0]     num_a,
  input  logic [rar_pkg::DEN_W-1:0]            den_a,
  input  logic signed [rar_pkg::NUM_W-1:0]     num_b,
  input  logic [rar_pkg::DEN_W-1:0]            den_b,
  input  logic                                 q_full,
  output logic                                 push,
  output rar_pkg::frac_t                       push_data
);

  logic                                    s1_valid_r;
  rar_pkg::opcode_t                        op_r;
  rar_pkg::status_t                        status_r;
  logic                                    nb_neg_r;
  logic signed [rar_pkg::RES_NUM_W-1:0]    m1_r;
  logic signed [rar_pkg::RES_NUM_W-1:0]    m2_r;
  logic [rar_pkg::RES_DEN_W-1:0]           m3_r;

  logic signed [rar_pkg::NUM_W:0]          mb_a;
  logic signed [rar_pkg::NUM_W:0]          mb_b;
  logic signed [2*rar_pkg::NUM_W+1:0]      m2_full;
  logic signed [2*rar_pkg::NUM_W-1:0]      m1_full;
  logic [rar_pkg::NUM_W-1:0]               nb_abs;
  logic [rar_pkg::NUM_W-1:0]               m3_b;
  logic [rar_pkg::DEN_W+rar_pkg::NUM_W-1:0] m3_full;
  rar_pkg::status_t                        status_in;
  logic                                    accept;
  logic signed [rar_pkg::RES_NUM_W-1:0]    n_comb;

  assign in_ready = !s1_valid_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = s1_valid_r && !q_full;

  // Classify operands and form the three products.
  always_comb begin
    nb_abs = num_b[rar_pkg::NUM_W-1] ? rar_pkg::NUM_W'(-num_b) : num_b;
    if (opcode == rar_pkg::OP_MUL) begin
      mb_a = {num_a[rar_pkg::NUM_W-1], num_a};
      mb_b = {num_b[rar_pkg::NUM_W-1], num_b};
    end else begin
      mb_a = {num_b[rar_pkg::NUM_W-1], num_b};
      mb_b = $signed({2'b00, den_a});
    end
    m1_full = num_a * $signed({1'b0, den_b});
    m2_full = mb_a * mb_b;
    m3_b    = (opcode == rar_pkg::OP_DIV) ? nb_abs : {1'b0, den_b};
    m3_full = den_a * m3_b;
    if (den_a == '0 || den_b == '0) begin
      status_in = rar_pkg::ST_ZERO_DEN;
    end else if (opcode == rar_pkg::OP_DIV && num_b == '0) begin
      status_in = rar_pkg::ST_DIV_ZERO;
    end else begin
      status_in = rar_pkg::ST_OK;
    end
  end

  // Hold the stage-one valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (push) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Capture products of an accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= opcode;
      status_r <= status_in;
      nb_neg_r <= num_b[rar_pkg::NUM_W-1];
      m1_r     <= rar_pkg::RES_NUM_W'(m1_full);
      m2_r     <= m2_full[rar_pkg::RES_NUM_W-1:0];
      m3_r     <= rar_pkg::RES_DEN_W'(m3_full);
    end
  end

  // Combine the cross products into the unreduced numerator.
  always_comb begin
    unique case (op_r)
      rar_pkg::OP_ADD: n_comb = m1_r + m2_r;
      rar_pkg::OP_SUB: n_comb = m1_r - m2_r;
      rar_pkg::OP_MUL: n_comb = m2_r;
      rar_pkg::OP_DIV: n_comb = nb_neg_r ? -m1_r : m1_r;
      default:         n_comb = m1_r;
    endcase
    push_data.status = status_r;
    push_data.n      = n_comb;
    push_data.d      = m3_r;
  end

endmodule

@@ rtl/rar_queue.sv @@
// Two-entry queue between the front end and the reduction back end.
// Depends on rar_pkg for the entry type and depth.
`include "rational_arith_reduce_unit_macros.svh"
module rar_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rar_pkg::frac_t  push_data,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output rar_pkg::frac_t  head
);

  rar_pkg::frac_t                 mem_r [rar_pkg::QDEPTH];
  logic [rar_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [rar_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [rar_pkg::QPTR_W:0]       count_r;

  assign full  = (count_r == (rar_pkg::QPTR_W+1)'(rar_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store entries.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `RAR_ASSERT_IMP(a_no_overflow, push, !full || pop, "queue push while full")
  `RAR_ASSERT_IMP(a_no_underflow, pop, !empty, "queue pop while empty")
  `RAR_ASSERT_NXT(a_count_range, 1'b1, count_r <= (rar_pkg::QPTR_W+1)'(rar_pkg::QDEPTH),
                  "queue count out of range")

endmodule

@@ rtl/rar_back.sv @@
// Back end: binary gcd, two-lane restoring division by the gcd, result register.
// Depends on rar_pkg; pops unreduced fractions from rar_queue.
`include "rational_arith_reduce_unit_macros.svh"
module rar_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty,
  input  rar_pkg::frac_t                         q_head,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [rar_pkg::RES_NUM_W-1:0]   res_num,
  output logic [rar_pkg::RES_DEN_W-1:0]          res_den,
  output rar_pkg::status_t                       status
);

  localparam int W = rar_pkg::MAG_W;

  rar_pkg::back_state_t                   state_r, state_nxt;
  logic [W-1:0]                           u_r, u_nxt;
  logic [W-1:0]                           v_r, v_nxt;
  logic [rar_pkg::SHIFT_W-1:0]            k_r, k_nxt;
  logic [W-1:0]                           g_r, g_nxt;
  logic                                   neg_r, neg_nxt;
  logic [W-1:0]                           rem_m_r, rem_m_nxt;
  logic [W-1:0]                           rem_d_r, rem_d_nxt;
  logic [W-1:0]                           q_m_r, q_m_nxt;
  logic [W-1:0]                           q_d_r, q_d_nxt;
  logic [rar_pkg::SHIFT_W-1:0]            cnt_r, cnt_nxt;
  logic                                   out_valid_r, out_valid_nxt;
  logic signed [rar_pkg::RES_NUM_W-1:0]   res_num_r, res_num_nxt;
  logic [rar_pkg::RES_DEN_W-1:0]          res_den_r, res_den_nxt;
  rar_pkg::status_t                       status_r, status_nxt;

  logic                                   out_free;
  logic [W-1:0]                           head_mag;
  logic [W:0]                             sh_m, sh_d;
  logic [W+1:0]                           tr_m, tr_d;
  logic [W-1:0]                           diff_uv, diff_vu;

  assign out_valid = out_valid_r;
  assign res_num   = res_num_r;
  assign res_den   = res_den_r;
  assign status    = status_r;
  assign out_free  = !out_valid_r || out_ready;

  // Datapath helpers: magnitude of the head, subtractions, division trial.
  always_comb begin
    head_mag = q_head.n[rar_pkg::RES_NUM_W-1] ? W'(-q_head.n) : W'(q_head.n);
    diff_uv  = u_r - v_r;
    diff_vu  = v_r - u_r;
    sh_m     = {rem_m_r, q_m_r[W-1]};
    sh_d     = {rem_d_r, q_d_r[W-1]};
    tr_m     = {1'b0, sh_m} - {2'b00, g_r};
    tr_d     = {1'b0, sh_d} - {2'b00, g_r};
  end

  // Sequence one fraction: load, gcd, divide, deliver.
  always_comb begin
    state_nxt     = state_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    neg_nxt       = neg_r;
    rem_m_nxt     = rem_m_r;
    rem_d_nxt     = rem_d_r;
    q_m_nxt       = q_m_r;
    q_d_nxt       = q_d_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    status_nxt    = status_r;
    pop           = 1'b0;
    unique case (state_r)
      rar_pkg::B_IDLE: begin
        if (!q_empty) begin
          if (q_head.status != rar_pkg::ST_OK) begin
            // Error: zero result with the error status.
            if (out_free) begin
              pop           = 1'b1;
              out_valid_nxt = 1'b1;
              res_num_nxt   = '0;
              res_den_nxt   = '0;
              status_nxt    = q_head.status;
            end
          end else if (q_head.n == '0) begin
            // Zero numerator reduces to zero over one.
            if (out_free) begin
              pop           = 1'b1;
              out_valid_nxt = 1'b1;
              res_num_nxt   = '0;
              res_den_nxt   = rar_pkg::RES_DEN_W'(1);
              status_nxt    = rar_pkg::ST_OK;
            end
          end else begin
            pop       = 1'b1;
            u_nxt     = head_mag;
            v_nxt     = q_head.d;
            k_nxt     = '0;
            neg_nxt   = q_head.n[rar_pkg::RES_NUM_W-1];
            q_m_nxt   = head_mag;
            q_d_nxt   = q_head.d;
            state_nxt = rar_pkg::B_GCD;
          end
        end
      end
      rar_pkg::B_GCD: begin
        if (u_r == v_r) begin
          g_nxt     = W'(u_r << k_r);
          rem_m_nxt = '0;
          rem_d_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = rar_pkg::B_DIV;
        end else if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (u_r > v_r) begin
          u_nxt = diff_uv >> 1;
        end else begin
          v_nxt = diff_vu >> 1;
        end
      end
      rar_pkg::B_DIV: begin
        // One quotient bit per lane per cycle.
        rem_m_nxt = tr_m[W+1] ? sh_m[W-1:0] : tr_m[W-1:0];
        rem_d_nxt = tr_d[W+1] ? sh_d[W-1:0] : tr_d[W-1:0];
        q_m_nxt   = {q_m_r[W-2:0], !tr_m[W+1]};
        q_d_nxt   = {q_d_r[W-2:0], !tr_d[W+1]};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == rar_pkg::SHIFT_W'(W - 1)) begin
          state_nxt = rar_pkg::B_OUT;
        end
      end
      rar_pkg::B_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_num_nxt   = neg_r ? -$signed({1'b0, q_m_r}) : $signed({1'b0, q_m_r});
          res_den_nxt   = q_d_r;
          status_nxt    = rar_pkg::ST_OK;
          state_nxt     = rar_pkg::B_IDLE;
        end
      end
      default: state_nxt = rar_pkg::B_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rar_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    k_r       <= k_nxt;
    g_r       <= g_nxt;
    neg_r     <= neg_nxt;
    rem_m_r   <= rem_m_nxt;
    rem_d_r   <= rem_d_nxt;
    q_m_r     <= q_m_nxt;
    q_d_r     <= q_d_nxt;
    cnt_r     <= cnt_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    status_r  <= status_nxt;
  end

  `RAR_ASSERT_IMP(a_gcd_nonzero, state_r == rar_pkg::B_GCD, u_r != '0 && v_r != '0,
                  "gcd operand became zero")
  `RAR_ASSERT_IMP(a_ok_den_pos, out_valid_r && status_r == rar_pkg::ST_OK, res_den_r != '0,
                  "ok result with zero denominator")
  `RAR_ASSERT_IMP(a_err_zero, out_valid_r && status_r != rar_pkg::ST_OK,
                  res_num_r == '0 && res_den_r == '0, "error result not zero")
  `RAR_ASSERT_NXT(a_div_to_out,
                  state_r == rar_pkg::B_DIV && cnt_r == rar_pkg::SHIFT_W'(W - 1),
                  state_r == rar_pkg::B_OUT, "division did not finish on count")

endmodule
